FILE: hw/rtl/adamwu_pkg.sv
// ----------------------------------------------------------------------------
// adamwu_pkg
// shared types and constants of the adam weight update unit
// ----------------------------------------------------------------------------
package adamwu_pkg;

  localparam int unsigned MaxWeights = 4096;
  localparam int unsigned IdxW       = $clog2(MaxWeights);
  localparam int unsigned CfgIdxW    = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgBetaOne  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBetaTwo  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEpsilon  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLearnRt  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWeights  = 3'd4;

  // register reset values
  localparam logic [31:0] BetaOneRst  = 32'd3865470566;
  localparam logic [31:0] BetaTwoRst  = 32'd4290672329;
  localparam logic [31:0] EpsilonRst  = 32'd2814750;
  localparam logic [31:0] LearnRtRst  = 32'd4294967;
  localparam logic [12:0] WeightsRst  = 13'd4096;

  localparam logic [32:0] One32       = 33'h1_0000_0000;
  localparam logic [33:0] StepCap     = 34'h2_0000_0000;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_MA, ST_MB, ST_MC,
    ST_VA, ST_VB, ST_VC, ST_VD, ST_WB,
    ST_DIVM, ST_VSET, ST_DIVV, ST_SQSET, ST_SQRT,
    ST_PL, ST_PH, ST_PD, ST_DIVS,
    ST_POW1, ST_POW2, ST_POW3, ST_OUT
  } state_e;

endpackage

FILE: hw/rtl/adam_weight_update.sv
// ----------------------------------------------------------------------------
// adam_weight_update
// adam optimizer step: moment update, bias correction, saturated weight step
// ----------------------------------------------------------------------------
// one item at a time; the run time is set by the bit-serial divider
//   (64 + 64 + 34 steps) and the 32-step square root, and is shorter when
//   the second moment saturates or the step needs no division
// the next input beat is taken while a finished result still waits
// reset: a clearing pass zeroes all 4096 entries of both moment memories before
//   the first input beat is taken; configuration writes are taken meanwhile
module adam_weight_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // weight_value, gradient_value, weight_index
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // updated_weight
  output logic [0:0]  m_axis_tuser,   // pass_complete
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [adamwu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import adamwu_pkg::*;

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;
  logic [IdxW-1:0] clr_q;
  logic [IdxW-1:0] cnt_q;
  logic            done_q;
  logic            vsat_q;
  logic            sdiv_q;

  // configuration and running powers
  logic [31:0] beta_one_q, beta_two_q, eps_q, lr_q;
  logic [12:0] wiu_q;
  logic [31:0] p1_q, p2_q;

  // item registers
  logic signed [31:0] w_q, g_q;
  logic [IdxW-1:0]    idx_q;

  // moment memories, registered read
  logic [31:0] m_mem [MaxWeights];
  logic [63:0] v_mem [MaxWeights];
  logic [31:0] m_rd_q;
  logic [63:0] v_rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [31:0]     mem_wm;
  logic [63:0]     mem_wv;

  // shared multiplier, registered product
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  // datapath registers
  logic signed [67:0] acc_q;
  logic signed [31:0] mnew_q;
  logic [63:0] g2_q, vacc_q, vnew_q;
  logic        neg_q;
  logic [63:0] mhat_q;
  logic [63:0] plo_q;
  logic [56:0] denom_q;
  logic [33:0] step_q;

  // bit-serial divider
  logic [63:0] dr_q, db_q, dq_q, dd_q;
  logic [6:0]  dn_q;

  // square root
  logic [63:0] sv_q, sr_q;
  logic [4:0]  sk_q;

  // output register
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_user_q;

  // ----------------------------------------------------- combinational helpers
  logic        in_acc, cfg_acc, out_free;
  logic [32:0] nb1, nb2, d1, d2;
  logic [31:0] gmag, mmag;
  logic signed [67:0] msum;
  logic [63:0] vnew_c;
  logic        vsat_c;
  logic [64:0] div_rs;
  logic        div_ge;
  logic [63:0] sq_bit, sq_t;
  logic [95:0] p96;
  logic        step_zero, step_cap;
  logic [12:0] plen, cnt_inc;
  logic        pass_end;
  logic signed [35:0] res_w;
  logic [31:0] res_sat;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !m_valid_q || m_axis_tready;

  assign nb1  = One32 - {1'b0, beta_one_q};
  assign nb2  = One32 - {1'b0, beta_two_q};
  assign d1   = One32 - {1'b0, p1_q};
  assign d2   = One32 - {1'b0, p2_q};
  assign gmag = g_q[31] ? 32'(-g_q) : 32'(g_q);
  assign mmag = mnew_q[31] ? 32'(-mnew_q) : 32'(mnew_q);

  // floor of the convex sum over 2^32 is the upper word of the sum
  assign msum   = acc_q + prod_q;
  assign vnew_c = vacc_q + {32'b0, prod_q[63:32]};
  // bias corrected second moment would need more than 64 bits
  assign vsat_c = {1'b0, vnew_q[63:32]} >= d2;

  // one restoring division step
  assign div_rs = {dr_q, db_q[63]};
  assign div_ge = div_rs >= {1'b0, dd_q};

  // one step of the digit-by-digit root
  assign sq_bit = 64'(1) << {sk_q, 1'b0};
  assign sq_t   = sr_q + sq_bit;

  // lr * mhat over 2^16 scale: upper partial product in prod_q
  assign p96       = {prod_q[63:0], 32'b0} + {32'b0, plo_q};
  assign step_zero = (mhat_q == 64'b0);
  assign step_cap  = (denom_q == 57'b0) || (p96[95:18] >= {21'b0, denom_q});

  // pass length clamps into one to the store depth
  always_comb begin
    plen = wiu_q;
    if (wiu_q == 13'd0) plen = 13'd1;
    else if (wiu_q > 13'(MaxWeights)) plen = 13'(MaxWeights);
  end
  assign cnt_inc  = {1'b0, cnt_q} + 13'd1;
  assign pass_end = cnt_inc >= plen;

  // step is taken against the sign of the first moment
  assign res_w = neg_q ? (36'(w_q) + $signed({2'b0, step_q}))
                       : (36'(w_q) - $signed({2'b0, step_q}));
  always_comb begin
    if (res_w > 36'sh0_7FFF_FFFF) res_sat = 32'h7FFF_FFFF;
    else if (res_w < -36'sh0_8000_0000) res_sat = 32'h8000_0000;
    else res_sat = res_w[31:0];
  end

  // ------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == IdxW'(MaxWeights - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_MA;
      ST_MA:    state_d = ST_MB;
      ST_MB:    state_d = ST_MC;
      ST_MC:    state_d = ST_VA;
      ST_VA:    state_d = ST_VB;
      ST_VB:    state_d = ST_VC;
      ST_VC:    state_d = ST_VD;
      ST_VD:    state_d = ST_WB;
      ST_WB:    state_d = ST_DIVM;
      ST_DIVM:  if (dn_q == 7'd1) state_d = ST_VSET;
      ST_VSET:  state_d = vsat_c ? ST_SQSET : ST_DIVV;
      ST_DIVV:  if (dn_q == 7'd1) state_d = ST_SQSET;
      ST_SQSET: state_d = ST_SQRT;
      ST_SQRT:  if (sk_q == 5'd0) state_d = ST_PL;
      ST_PL:    state_d = ST_PH;
      ST_PH:    state_d = ST_PD;
      ST_PD:    state_d = (step_zero || step_cap) ? ST_POW1 : ST_DIVS;
      ST_DIVS:  if (dn_q == 7'd1) state_d = ST_POW1;
      ST_POW1:  state_d = ST_POW2;
      ST_POW2:  state_d = ST_POW3;
      ST_POW3:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_q;
    mem_raddr     = idx_q;
    mem_wm        = mnew_q;
    mem_wv        = vnew_c;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wm    = '0;
        mem_wv    = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_raddr     = s_axis_tdata[64 +: IdxW];
      end
      ST_MA: begin
        mul_a = {{2{m_rd_q[31]}}, m_rd_q};
        mul_b = {2'b0, beta_one_q};
      end
      ST_MB: begin
        mul_a = {1'b0, nb1};
        mul_b = 34'(g_q);
      end
      ST_MC: begin
        mul_a = {2'b0, gmag};
        mul_b = {2'b0, gmag};
      end
      ST_VA: begin
        mul_a = {2'b0, v_rd_q[63:32]};
        mul_b = {2'b0, beta_two_q};
      end
      ST_VB: begin
        mul_a = {2'b0, v_rd_q[31:0]};
        mul_b = {2'b0, beta_two_q};
      end
      ST_VC: begin
        mul_a = {2'b0, g2_q[63:32]};
        mul_b = {1'b0, nb2};
      end
      ST_VD: begin
        mul_a = {2'b0, g2_q[31:0]};
        mul_b = {1'b0, nb2};
      end
      ST_WB:  mem_we = 1'b1;
      ST_PL: begin
        mul_a = {2'b0, mhat_q[31:0]};
        mul_b = {2'b0, lr_q};
      end
      ST_PH: begin
        mul_a = {2'b0, mhat_q[63:32]};
        mul_b = {2'b0, lr_q};
      end
      ST_POW1: begin
        mul_a = {2'b0, p1_q};
        mul_b = {2'b0, beta_one_q};
      end
      ST_POW2: begin
        mul_a = {2'b0, p2_q};
        mul_b = {2'b0, beta_two_q};
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // --------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      m_mem[mem_waddr] <= mem_wm;
      v_mem[mem_waddr] <= mem_wv;
    end
    m_rd_q <= m_mem[mem_raddr];
    v_rd_q <= v_mem[mem_raddr];
  end

  // ------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      beta_one_q <= BetaOneRst;
      beta_two_q <= BetaTwoRst;
      eps_q      <= EpsilonRst;
      lr_q       <= LearnRtRst;
      wiu_q      <= WeightsRst;
      p1_q       <= BetaOneRst;
      p2_q       <= BetaTwoRst;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IdxW'(1);

      // a beta write restarts its running power
      if (cfg_acc) begin
        case (cfg_index_i)
          CfgBetaOne: begin
            beta_one_q <= cfg_data_i;
            p1_q       <= cfg_data_i;
          end
          CfgBetaTwo: begin
            beta_two_q <= cfg_data_i;
            p2_q       <= cfg_data_i;
          end
          CfgEpsilon: eps_q <= cfg_data_i;
          CfgLearnRt: lr_q  <= cfg_data_i;
          CfgWeights: wiu_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end

      // end of pass bookkeeping, after this item's corrections are done
      if (state_q == ST_POW1) begin
        done_q <= pass_end;
        cnt_q  <= pass_end ? '0 : cnt_inc[IdxW-1:0];
      end
      if (state_q == ST_POW2 && done_q) p1_q <= prod_q[63:32];
      if (state_q == ST_POW3 && done_q) p2_q <= prod_q[63:32];

      if (state_q == ST_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // -------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        w_q   <= s_axis_tdata[31:0];
        g_q   <= s_axis_tdata[63:32];
        idx_q <= s_axis_tdata[64 +: IdxW];
      end
      ST_MB: acc_q  <= prod_q;
      ST_MC: mnew_q <= msum[63:32];
      ST_VA: g2_q   <= prod_q[63:0];
      ST_VB: vacc_q <= prod_q[63:0];
      ST_VC: vacc_q <= vacc_q + {32'b0, prod_q[63:32]};
      ST_VD: vacc_q <= vacc_q + prod_q[63:0];
      ST_WB: begin
        vnew_q <= vnew_c;
        neg_q  <= mnew_q[31];
        // mhat = |m| * 2^32 / (1 - beta1^t)
        dr_q   <= '0;
        db_q   <= {mmag, 32'b0};
        dd_q   <= {31'b0, d1};
        dq_q   <= '0;
        dn_q   <= 7'd64;
      end
      ST_DIVM, ST_DIVV, ST_DIVS: begin
        dr_q <= div_ge ? 64'(div_rs - {1'b0, dd_q}) : div_rs[63:0];
        dq_q <= {dq_q[62:0], div_ge};
        db_q <= {db_q[62:0], 1'b0};
        dn_q <= dn_q - 7'd1;
      end
      ST_VSET: begin
        mhat_q <= dq_q;
        vsat_q <= vsat_c;
        // vhat = v * 2^32 / (1 - beta2^t), upper word already below divisor
        dr_q   <= {32'b0, vnew_q[63:32]};
        db_q   <= {vnew_q[31:0], 32'b0};
        dd_q   <= {31'b0, d2};
        dq_q   <= '0;
        dn_q   <= 7'd64;
      end
      ST_SQSET: begin
        sv_q <= vsat_q ? '1 : dq_q;
        sr_q <= '0;
        sk_q <= 5'd31;
      end
      ST_SQRT: begin
        if (sv_q >= sq_t) begin
          sv_q <= sv_q - sq_t;
          sr_q <= (sr_q >> 1) + sq_bit;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sk_q <= sk_q - 5'd1;
      end
      ST_PL: denom_q <= {1'b0, sr_q[31:0], 24'b0} + {25'b0, eps_q};
      ST_PH: plo_q   <= prod_q[63:0];
      ST_PD: begin
        sdiv_q <= !(step_zero || step_cap);
        step_q <= step_zero ? '0 : StepCap;
        // quotient known below 2^34: start from the upper part of the dividend
        dr_q   <= p96[81:18];
        db_q   <= {p96[17:0], 46'b0};
        dd_q   <= {7'b0, denom_q};
        dq_q   <= '0;
        dn_q   <= 7'd34;
      end
      ST_POW1: if (sdiv_q) step_q <= (dq_q[33:0] > StepCap) ? StepCap : dq_q[33:0];
      ST_OUT: begin
        if (out_free) begin
          m_data_q <= res_sat;
          m_user_q <= done_q;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MA)
    else $error("accepted beat did not start the update");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVM || state_q == ST_DIVV || state_q == ST_DIVS) |-> dn_q != 7'd0)
    else $error("divider ran past its step count");

  a_pass_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free && done_q) |=> (cnt_q == '0 && m_axis_tuser == 1'b1))
    else $error("pass end without counter wrap");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |=> state_q == ST_DIVM && $stable(idx_q))
    else $error("write back left the update sequence");

endmodule
